// ===== rtl/ppmg_pkg.sv =====
// shared types and codes for the ppm p6 gray decoder
`default_nettype none

package ppmg_pkg;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_PIXEL  = 2'd1,
        KIND_ERROR  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ERR_MAGIC     = 2'd0,
        ERR_MALFORMED = 2'd1,
        ERR_TOO_LARGE = 2'd2
    } err_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  gray;
        logic [12:0] width;
        logic [12:0] height;
        logic [15:0] max_value;
        err_t        error_code;
        logic        last_pixel;
    } result_t;

    localparam logic [7:0] CHAR_P     = 8'h50;
    localparam logic [7:0] CHAR_6     = 8'h36;
    localparam logic [7:0] CHAR_LF    = 8'h0a;
    localparam logic [7:0] CHAR_HASH  = 8'h23;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [20:0] MAXVAL_LIMIT = 21'd65535;

endpackage

`default_nettype wire

// ===== rtl/ppm_p6_gray_decoder.sv =====
// ppm p6 byte stream decoder producing header, gray pixel and error results
//
// input channel: one file byte per request on data_byte, with file_start
// high on the first byte of a file; in_valid / in_stall handshake.
// output channel: one result per request (header, gray pixel or error)
// on kind and its fields; out_valid / out_stall handshake.
// bytes that finish no result are absorbed without any output.
// a byte passes the input register, then parser logic into the result
// register. throughput: one byte per cycle while out_stall is low; the
// parser state updates once per byte. reset clears the valid bits of
// both registers and returns the parser to the start of a file; file_start
// does the same for the byte that carries it. a stalled receiver holds
// the result register; the held byte then waits in the input register
// and in_stall rises until the result is taken. after an error, the last
// pixel or a zero width or height, all bytes are dropped until file_start.
`default_nettype none

module ppm_p6_gray_decoder #(
    parameter int unsigned MAX_DIMENSION = 4096
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        file_start,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       kind,
    output logic [7:0]       gray,
    output logic [12:0]      width,
    output logic [12:0]      height,
    output logic [15:0]      max_value,
    output logic [1:0]       error_code,
    output logic             last_pixel
);
    import ppmg_pkg::*;

    logic       held_valid;
    logic [7:0] held_byte;
    logic       held_start;
    logic       free;
    logic       step;
    logic       res_valid;
    result_t    res;
    result_t    out_res;

    assign step = held_valid && free;

    ppmg_in_reg u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .data_byte  (data_byte),
        .file_start (file_start),
        .take       (free),
        .held_valid (held_valid),
        .held_byte  (held_byte),
        .held_start (held_start)
    );

    ppmg_parse #(
        .MAX_DIMENSION (MAX_DIMENSION)
    ) u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .data_byte  (held_byte),
        .file_start (held_start),
        .res_valid  (res_valid),
        .res        (res)
    );

    ppmg_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (step),
        .res_valid (res_valid),
        .res       (res),
        .free      (free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_res   (out_res)
    );

    assign kind       = out_res.kind;
    assign gray       = out_res.gray;
    assign width      = out_res.width;
    assign height     = out_res.height;
    assign max_value  = out_res.max_value;
    assign error_code = out_res.error_code;
    assign last_pixel = out_res.last_pixel;

endmodule

`default_nettype wire

// ===== rtl/ppmg_in_reg.sv =====
// input register stage with stall back to the sender
`default_nettype none

module ppmg_in_reg (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] data_byte,
    input  wire logic       file_start,
    input  wire logic       take,
    output logic            held_valid,
    output logic [7:0]      held_byte,
    output logic            held_start
);
    import ppmg_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       start_reg;

    // held request blocks the port until the parser takes it
    assign in_stall   = valid_reg && !take;
    assign valid_next = in_stall ? 1'b1 : in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            byte_reg  <= data_byte;
            start_reg <= file_start;
        end
    end

    assign held_valid = valid_reg;
    assign held_byte  = byte_reg;
    assign held_start = start_reg;

endmodule

`default_nettype wire

// ===== rtl/ppmg_parse.sv =====
// header parser state, pixel averaging and result formation
`default_nettype none

module ppmg_parse #(
    parameter int unsigned MAX_DIMENSION = 4096
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step,
    input  wire logic [7:0]        data_byte,
    input  wire logic              file_start,
    output logic                   res_valid,
    output ppmg_pkg::result_t      res
);
    import ppmg_pkg::*;

    typedef enum logic [3:0] {
        PH_MAGIC_P   = 4'd0,
        PH_MAGIC_6   = 4'd1,
        PH_THIRD     = 4'd2,
        PH_CMT_CHECK = 4'd3,
        PH_CMT_SKIP  = 4'd4,
        PH_W_SKIP    = 4'd5,
        PH_W_DIG     = 4'd6,
        PH_H_SKIP    = 4'd7,
        PH_H_DIG     = 4'd8,
        PH_M_SKIP    = 4'd9,
        PH_M_DIG     = 4'd10,
        PH_TO_NL     = 4'd11,
        PH_PIXELS    = 4'd12,
        PH_HALT      = 4'd13
    } phase_t;

    localparam logic [20:0] DIM_LIMIT = 21'(MAX_DIMENSION);

    function automatic logic is_space(input logic [7:0] c);
        return c == 8'h20 || c == 8'h09 || c == 8'h0a || c == 8'h0b ||
               c == 8'h0c || c == 8'h0d;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= CHAR_ZERO && c <= CHAR_NINE;
    endfunction

    // floor(x/3) for x below 768 by reciprocal multiply
    function automatic logic [7:0] div3(input logic [9:0] x);
        logic [20:0] p;
        p = 21'(x) * 21'd683;
        return p[18:11];
    endfunction

    phase_t      phase_reg, phase_next, eff_phase, skip_base;
    logic [16:0] acc_reg, acc_next, eff_acc;
    logic [12:0] w_reg, w_next, eff_w;
    logic [12:0] h_reg, h_next, eff_h;
    logic [15:0] maxv_reg, maxv_next, eff_maxv;
    logic [12:0] col_reg, col_next, eff_col;
    logic [12:0] row_reg, row_next, eff_row;
    logic [1:0]  idx_reg, idx_next, eff_idx;
    logic [9:0]  sum_reg, sum_next, eff_sum, sum_add;
    logic [3:0]  digit;
    logic [20:0] acc_val;
    logic [20:0] limit;
    logic        do_skip;
    logic        do_nl;
    logic        col_end;
    logic        row_end;
    logic        is_last;
    logic        emit;
    kind_t       kind_c;
    err_t        err_c;
    logic [7:0]  gray_c;
    logic        last_c;

    always_comb
    begin
        // a file start clears everything before the byte is parsed
        eff_phase = file_start ? PH_MAGIC_P : phase_reg;
        eff_acc   = file_start ? 17'd0 : acc_reg;
        eff_w     = file_start ? 13'd0 : w_reg;
        eff_h     = file_start ? 13'd0 : h_reg;
        eff_maxv  = file_start ? 16'd0 : maxv_reg;
        eff_col   = file_start ? 13'd0 : col_reg;
        eff_row   = file_start ? 13'd0 : row_reg;
        eff_idx   = file_start ? 2'd0 : idx_reg;
        eff_sum   = file_start ? 10'd0 : sum_reg;

        digit   = 4'(data_byte - CHAR_ZERO);
        acc_val = 21'({eff_acc, 3'b000}) + 21'({eff_acc, 1'b0}) + 21'(digit);
        limit   = (eff_phase == PH_M_DIG) ? MAXVAL_LIMIT : DIM_LIMIT;
        sum_add = eff_sum + 10'(data_byte);
        col_end = (14'(eff_col) + 14'd1) >= 14'(eff_w);
        row_end = (14'(eff_row) + 14'd1) >= 14'(eff_h);
        is_last = col_end && row_end;

        phase_next = eff_phase;
        acc_next   = eff_acc;
        w_next     = eff_w;
        h_next     = eff_h;
        maxv_next  = eff_maxv;
        col_next   = eff_col;
        row_next   = eff_row;
        idx_next   = eff_idx;
        sum_next   = eff_sum;
        do_skip    = 1'b0;
        do_nl      = 1'b0;
        skip_base  = PH_W_SKIP;
        emit       = 1'b0;
        kind_c     = KIND_HEADER;
        err_c      = ERR_MAGIC;
        gray_c     = 8'd0;
        last_c     = 1'b0;

        case (eff_phase)
            PH_MAGIC_P, PH_MAGIC_6:
            begin
                if (data_byte != ((eff_phase == PH_MAGIC_P) ? CHAR_P : CHAR_6))
                begin
                    phase_next = PH_HALT;
                    emit       = 1'b1;
                    kind_c     = KIND_ERROR;
                    err_c      = ERR_MAGIC;
                end
                else
                begin
                    phase_next = (eff_phase == PH_MAGIC_P) ? PH_MAGIC_6 : PH_THIRD;
                end
            end
            PH_THIRD, PH_CMT_CHECK:
            begin
                // a newline right after the magic is eaten, else look for comment
                if (eff_phase == PH_THIRD && data_byte == CHAR_LF)
                begin
                    phase_next = PH_CMT_CHECK;
                end
                else if (data_byte == CHAR_HASH)
                begin
                    phase_next = PH_CMT_SKIP;
                end
                else
                begin
                    do_skip   = 1'b1;
                    skip_base = PH_W_SKIP;
                end
            end
            PH_CMT_SKIP:
            begin
                if (data_byte == CHAR_LF)
                begin
                    phase_next = PH_CMT_CHECK;
                end
            end
            PH_W_SKIP, PH_H_SKIP, PH_M_SKIP:
            begin
                do_skip   = 1'b1;
                skip_base = eff_phase;
            end
            PH_W_DIG, PH_H_DIG, PH_M_DIG:
            begin
                if (is_digit(data_byte))
                begin
                    if (acc_val > limit)
                    begin
                        phase_next = PH_HALT;
                        emit       = 1'b1;
                        kind_c     = KIND_ERROR;
                        err_c      = ERR_TOO_LARGE;
                    end
                    else
                    begin
                        acc_next = acc_val[16:0];
                    end
                end
                else
                begin
                    // terminator is looked at again in this same step
                    acc_next = 17'd0;
                    case (eff_phase)
                        PH_W_DIG:
                        begin
                            w_next    = eff_acc[12:0];
                            do_skip   = 1'b1;
                            skip_base = PH_H_SKIP;
                        end
                        PH_H_DIG:
                        begin
                            h_next    = eff_acc[12:0];
                            do_skip   = 1'b1;
                            skip_base = PH_M_SKIP;
                        end
                        default:
                        begin
                            maxv_next = eff_acc[15:0];
                            do_nl     = 1'b1;
                        end
                    endcase
                end
            end
            PH_TO_NL:
            begin
                do_nl = 1'b1;
            end
            PH_PIXELS:
            begin
                if (eff_idx < 2'd2)
                begin
                    idx_next = eff_idx + 2'd1;
                    sum_next = sum_add;
                end
                else
                begin
                    emit     = 1'b1;
                    kind_c   = KIND_PIXEL;
                    gray_c   = div3(sum_add);
                    last_c   = is_last;
                    idx_next = 2'd0;
                    sum_next = 10'd0;
                    if (is_last)
                    begin
                        phase_next = PH_HALT;
                    end
                    else if (col_end)
                    begin
                        col_next = 13'd0;
                        row_next = eff_row + 13'd1;
                    end
                    else
                    begin
                        col_next = eff_col + 13'd1;
                    end
                end
            end
            default:
            begin
                phase_next = PH_HALT;
            end
        endcase

        if (do_skip)
        begin
            if (is_space(data_byte))
            begin
                phase_next = skip_base;
            end
            else if (is_digit(data_byte))
            begin
                acc_next = 17'(digit);
                case (skip_base)
                    PH_W_SKIP: phase_next = PH_W_DIG;
                    PH_H_SKIP: phase_next = PH_H_DIG;
                    default:   phase_next = PH_M_DIG;
                endcase
            end
            else
            begin
                phase_next = PH_HALT;
                emit       = 1'b1;
                kind_c     = KIND_ERROR;
                err_c      = ERR_MALFORMED;
            end
        end

        if (do_nl)
        begin
            if (data_byte == CHAR_LF)
            begin
                col_next   = 13'd0;
                row_next   = 13'd0;
                idx_next   = 2'd0;
                sum_next   = 10'd0;
                phase_next = (w_next == 13'd0 || h_next == 13'd0) ? PH_HALT : PH_PIXELS;
                emit       = 1'b1;
                kind_c     = KIND_HEADER;
            end
            else
            begin
                phase_next = PH_TO_NL;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_MAGIC_P;
            acc_reg   <= 17'd0;
            w_reg     <= 13'd0;
            h_reg     <= 13'd0;
            maxv_reg  <= 16'd0;
            col_reg   <= 13'd0;
            row_reg   <= 13'd0;
            idx_reg   <= 2'd0;
            sum_reg   <= 10'd0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            w_reg     <= w_next;
            h_reg     <= h_next;
            maxv_reg  <= maxv_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            idx_reg   <= idx_next;
            sum_reg   <= sum_next;
        end
    end

    assign res_valid      = emit;
    assign res.kind       = kind_c;
    assign res.gray       = gray_c;
    assign res.width      = w_next;
    assign res.height     = h_next;
    assign res.max_value  = maxv_next;
    assign res.error_code = err_c;
    assign res.last_pixel = last_c;

endmodule

`default_nettype wire

// ===== rtl/ppmg_out_reg.sv =====
// result register toward the receiver
`default_nettype none

module ppmg_out_reg (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load,
    input  wire logic              res_valid,
    input  wire ppmg_pkg::result_t res,
    output logic                   free,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output ppmg_pkg::result_t      out_res
);
    import ppmg_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    // register can take a new result when empty or being drained now
    assign free       = !valid_reg || !out_stall;
    assign valid_next = free ? (load && res_valid) : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && res_valid)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

`default_nettype wire

// ===== verif/ppm_p6_gray_checker.sv =====
// result predictor and comparator for the ppm p6 gray decoder channels
module ppm_p6_gray_checker #(
    parameter int unsigned MAX_DIMENSION = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        file_start,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [1:0]  kind,
    input  logic [7:0]  gray,
    input  logic [12:0] width,
    input  logic [12:0] height,
    input  logic [15:0] max_value,
    input  logic [1:0]  error_code,
    input  logic        last_pixel,
    output int          fail_count,
    output int          awaited
);
    timeunit 1ns;
    timeprecision 1ps;
    import ppmg_pkg::*;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_VT    = 8'h0b;
    localparam logic [7:0] CHAR_FF    = 8'h0c;
    localparam logic [7:0] CHAR_CR    = 8'h0d;
    localparam int unsigned MAXVAL_TOP = 65535;

    typedef enum logic [3:0] {
        AT_MAGIC_P,
        AT_MAGIC_6,
        AT_THIRD,
        AT_COMMENT_CHECK,
        IN_COMMENT,
        WIDTH_SKIP,
        WIDTH_DIGITS,
        HEIGHT_SKIP,
        HEIGHT_DIGITS,
        MAXVAL_SKIP,
        MAXVAL_DIGITS,
        TO_NEWLINE,
        IN_PIXELS,
        HALTED
    } parse_state_t;

    parse_state_t state;
    int unsigned  number;
    int unsigned  col;
    int unsigned  row;
    int unsigned  channel;
    int unsigned  channel_sum;
    logic [12:0]  img_width;
    logic [12:0]  img_height;
    logic [15:0]  img_maxval;
    result_t      decoded_q[$];

    function automatic bit is_digit(input logic [7:0] c);
        return c >= CHAR_ZERO && c <= CHAR_NINE;
    endfunction

    function automatic bit is_blank(input logic [7:0] c);
        return c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_LF || c == CHAR_VT ||
               c == CHAR_FF || c == CHAR_CR;
    endfunction

    function automatic result_t make_result(input kind_t k, input logic [7:0] g,
                                            input err_t e, input logic last);
        result_t r;
        r.kind       = k;
        r.gray       = g;
        r.width      = img_width;
        r.height     = img_height;
        r.max_value  = img_maxval;
        r.error_code = e;
        r.last_pixel = last;
        return r;
    endfunction

    task automatic clear_state();
        state       = AT_MAGIC_P;
        number      = 0;
        col         = 0;
        row         = 0;
        channel     = 0;
        channel_sum = 0;
        img_width   = '0;
        img_height  = '0;
        img_maxval  = '0;
    endtask

    // one byte through the parser; a terminating byte is looked at again by the next stage
    task automatic decode_byte(input logic [7:0] c, input logic restart);
        bit          done;
        bit          last;
        int unsigned value;
        int unsigned limit;
        if (restart)
            clear_state();
        done = 1'b0;
        for (int pass = 0; pass < 4 && !done; pass++)
        begin
            done = 1'b1;
            case (state)
                AT_MAGIC_P, AT_MAGIC_6:
                begin
                    if (c != ((state == AT_MAGIC_P) ? CHAR_P : CHAR_6))
                    begin
                        state = HALTED;
                        decoded_q.push_back(make_result(KIND_ERROR, 8'd0, ERR_MAGIC, 1'b0));
                    end
                    else
                        state = parse_state_t'(state + 4'd1);
                end
                AT_THIRD:
                begin
                    state = AT_COMMENT_CHECK;
                    done  = (c == CHAR_LF);
                end
                AT_COMMENT_CHECK:
                begin
                    if (c == CHAR_HASH)
                        state = IN_COMMENT;
                    else
                    begin
                        state = WIDTH_SKIP;
                        done  = 1'b0;
                    end
                end
                IN_COMMENT:
                begin
                    if (c == CHAR_LF)
                        state = AT_COMMENT_CHECK;
                end
                WIDTH_SKIP, HEIGHT_SKIP, MAXVAL_SKIP:
                begin
                    if (!is_blank(c))
                    begin
                        if (!is_digit(c))
                        begin
                            state = HALTED;
                            decoded_q.push_back(make_result(KIND_ERROR, 8'd0,
                                                            ERR_MALFORMED, 1'b0));
                        end
                        else
                        begin
                            number = c - CHAR_ZERO;
                            state  = parse_state_t'(state + 4'd1);
                        end
                    end
                end
                WIDTH_DIGITS, HEIGHT_DIGITS, MAXVAL_DIGITS:
                begin
                    limit = (state == MAXVAL_DIGITS) ? MAXVAL_TOP : MAX_DIMENSION;
                    if (is_digit(c))
                    begin
                        value = number * 10 + (c - CHAR_ZERO);
                        if (value > limit)
                        begin
                            state = HALTED;
                            decoded_q.push_back(make_result(KIND_ERROR, 8'd0,
                                                            ERR_TOO_LARGE, 1'b0));
                        end
                        else
                            number = value;
                    end
                    else
                    begin
                        if (state == WIDTH_DIGITS)
                            img_width = 13'(number);
                        else if (state == HEIGHT_DIGITS)
                            img_height = 13'(number);
                        else
                            img_maxval = 16'(number);
                        number = 0;
                        state  = parse_state_t'(state + 4'd1);
                        done   = 1'b0;
                    end
                end
                TO_NEWLINE:
                begin
                    if (c == CHAR_LF)
                    begin
                        col         = 0;
                        row         = 0;
                        channel     = 0;
                        channel_sum = 0;
                        state = (img_width == 0 || img_height == 0) ? HALTED : IN_PIXELS;
                        decoded_q.push_back(make_result(KIND_HEADER, 8'd0, ERR_MAGIC, 1'b0));
                    end
                end
                IN_PIXELS:
                begin
                    channel_sum += c;
                    if (channel < 2)
                        channel++;
                    else
                    begin
                        last = (col + 1 >= img_width) && (row + 1 >= img_height);
                        decoded_q.push_back(make_result(KIND_PIXEL, 8'(channel_sum / 3),
                                                        ERR_MAGIC, last));
                        channel     = 0;
                        channel_sum = 0;
                        if (last)
                            state = HALTED;
                        else if (col + 1 >= img_width)
                        begin
                            col = 0;
                            row = (row + 1) & 32'h1fff;
                        end
                        else
                            col = (col + 1) & 32'h1fff;
                    end
                end
                default:
                    state = HALTED;
            endcase
        end
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned seen);
        if (want != seen)
        begin
            fail_count++;
            $display("%0t ns: %s expected %0d actual %0d", $time, name, want, seen);
        end
    endtask

    task automatic compare_result();
        result_t want;
        if (decoded_q.size() == 0)
        begin
            fail_count++;
            $display("%0t ns: result with none expected, actual kind %0d gray %0d",
                     $time, kind, gray);
            return;
        end
        want = decoded_q.pop_front();
        check_field("kind", want.kind, kind);
        check_field("gray", want.gray, gray);
        check_field("width", want.width, width);
        check_field("height", want.height, height);
        check_field("max_value", want.max_value, max_value);
        check_field("error_code", want.error_code, error_code);
        check_field("last_pixel", want.last_pixel, last_pixel);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_state();
            decoded_q.delete();
            fail_count = 0;
            awaited <= 0;
        end
        else
        begin
            // a byte's result never leaves in the cycle it is taken, so compare first
            if (out_valid && !out_stall)
                compare_result();
            if (in_valid && !in_stall)
                decode_byte(data_byte, file_start);
            awaited <= decoded_q.size();
        end
    end

endmodule

// ===== verif/tb_ppm_p6_gray_decoder.sv =====
// testbench top for the ppm p6 gray decoder: file-shaped byte stimulus and verdict
module tb_ppm_p6_gray_decoder;
    timeunit 1ns;
    timeprecision 1ps;
    import ppmg_pkg::*;

    localparam int unsigned MAX_DIM      = 4096;
    localparam int          RANDOM_ITEMS = 1250;
    localparam int          HOLD_CYCLES  = 60;
    localparam int          CYCLE_LIMIT  = 400000;
    localparam logic [7:0]  BLANKS [6]   = '{8'h20, 8'h09, 8'h0a, 8'h0b, 8'h0c, 8'h0d};

    typedef enum {
        FAULT_NONE,
        FAULT_MAGIC,
        FAULT_SIGN,
        FAULT_OVERSIZE,
        FAULT_TERMINATOR,
        FAULT_NOISE,
        FAULT_CUT
    } fault_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  data_byte;
    logic        file_start;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  kind;
    logic [7:0]  gray;
    logic [12:0] width;
    logic [12:0] height;
    logic [15:0] max_value;
    logic [1:0]  error_code;
    logic        last_pixel;

    int          fail_count;
    int          awaited;
    int          idle_pct;
    int          stall_pct;
    int          hold_requests;
    int          phase_items;
    int          cycle_count = 0;
    logic [7:0]  file_q[$];

    ppm_p6_gray_decoder #(
        .MAX_DIMENSION(MAX_DIM)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .data_byte(data_byte),
        .file_start(file_start),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .kind(kind),
        .gray(gray),
        .width(width),
        .height(height),
        .max_value(max_value),
        .error_code(error_code),
        .last_pixel(last_pixel)
    );

    ppm_p6_gray_checker #(
        .MAX_DIMENSION(MAX_DIM)
    ) u_checker (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .data_byte(data_byte),
        .file_start(file_start),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .kind(kind),
        .gray(gray),
        .width(width),
        .height(height),
        .max_value(max_value),
        .error_code(error_code),
        .last_pixel(last_pixel),
        .fail_count(fail_count),
        .awaited(awaited)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("ppm_p6_gray_decoder: mismatch");
            $finish;
        end
    end

    // receiver: random stalls, plus a long hold-off each time one is requested
    initial
    begin
        int hold_left;
        int holds_seen;
        hold_left  = 0;
        holds_seen = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_requests != holds_seen)
            begin
                holds_seen = hold_requests;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    function automatic bit is_blank(input logic [7:0] b);
        for (int i = 0; i < 6; i++)
            if (b == BLANKS[i])
                return 1'b1;
        return 1'b0;
    endfunction

    // a byte that can neither start nor continue a number
    function automatic logic [7:0] pick_other();
        logic [7:0] b;
        do
            b = 8'($urandom);
        while ((b >= CHAR_ZERO && b <= CHAR_NINE) || is_blank(b));
        return b;
    endfunction

    function automatic logic [7:0] pick_except(input logic [7:0] avoid);
        logic [7:0] b;
        do
            b = 8'($urandom);
        while (b == avoid);
        return b;
    endfunction

    function automatic int unsigned pick_dimension();
        int r;
        r = $urandom_range(99);
        if (r < 4)
            return 0;
        if (r < 10)
            return MAX_DIM;
        if (r < 14)
            return $urandom_range(5, MAX_DIM);
        return $urandom_range(1, 4);
    endfunction

    function automatic int unsigned pick_maxval();
        int r;
        r = $urandom_range(99);
        if (r < 30)
            return 255;
        if (r < 40)
            return 65535;
        if (r < 45)
            return 0;
        return $urandom_range(1, 65535);
    endfunction

    task automatic put_number(input int unsigned value);
        string digits;
        digits = $sformatf("%0d", value);
        if ($urandom_range(9) == 0)
            repeat ($urandom_range(1, 2))
                file_q.push_back(CHAR_ZERO);
        for (int i = 0; i < digits.len(); i++)
            file_q.push_back(digits[i]);
    endtask

    task automatic load_text(input string s);
        file_q.delete();
        for (int i = 0; i < s.len(); i++)
            file_q.push_back(s[i]);
    endtask

    // mostly well-formed files with random content; the rest broken somewhere
    task automatic build_file();
        fault_t      fault;
        int          r;
        int          target;
        int unsigned value;
        int unsigned pixels;
        int unsigned dims[2];
        file_q.delete();
        r = $urandom_range(99);
        if (r < 68)
            fault = FAULT_NONE;
        else if (r < 72)
            fault = FAULT_MAGIC;
        else if (r < 77)
            fault = FAULT_SIGN;
        else if (r < 83)
            fault = FAULT_OVERSIZE;
        else if (r < 88)
            fault = FAULT_TERMINATOR;
        else if (r < 93)
            fault = FAULT_NOISE;
        else
            fault = FAULT_CUT;
        target = $urandom_range(2);

        if (fault == FAULT_NOISE)
        begin
            repeat ($urandom_range(1, 12))
                file_q.push_back(8'($urandom));
            return;
        end
        if (fault == FAULT_MAGIC)
        begin
            if (target == 0)
                file_q.push_back(pick_except(CHAR_P));
            else
            begin
                file_q.push_back(CHAR_P);
                file_q.push_back(pick_except(CHAR_6));
            end
            return;
        end
        file_q.push_back(CHAR_P);
        file_q.push_back(CHAR_6);

        r = $urandom_range(3);
        if (r == 0)
            file_q.push_back(CHAR_LF);
        else if (r == 1)
            file_q.push_back(BLANKS[$urandom_range(5)]);
        // comments are only seen right after the magic or its newline
        if (r != 1 && $urandom_range(2) == 0)
            repeat ($urandom_range(1, 2))
            begin
                file_q.push_back(CHAR_HASH);
                repeat ($urandom_range(5))
                    file_q.push_back(pick_except(CHAR_LF));
                file_q.push_back(CHAR_LF);
            end

        for (int f = 0; f < 3; f++)
        begin
            repeat ((f == 0) ? $urandom_range(2) : $urandom_range(1, 2))
                file_q.push_back(BLANKS[$urandom_range(5)]);
            if (fault == FAULT_SIGN && target == f)
            begin
                file_q.push_back(pick_other());
                return;
            end
            if (fault == FAULT_OVERSIZE && target == f)
            begin
                if (f < 2)
                    put_number($urandom_range(MAX_DIM + 1, 99999));
                else
                    put_number($urandom_range(65536, 999999));
                return;
            end
            value = (f < 2) ? pick_dimension() : pick_maxval();
            put_number(value);
            if (f < 2)
                dims[f] = value;
            if (fault == FAULT_TERMINATOR && target == f && f < 2)
            begin
                file_q.push_back(pick_other());
                return;
            end
        end

        if ($urandom_range(1) == 0)
            file_q.push_back(CHAR_LF);
        else
        begin
            file_q.push_back(pick_other());
            repeat ($urandom_range(3))
                file_q.push_back(pick_except(CHAR_LF));
            file_q.push_back(CHAR_LF);
        end

        // large images are only started; the next file cuts them off
        pixels = dims[0] * dims[1];
        if (pixels > 16)
            pixels = $urandom_range(5);
        repeat (pixels)
        begin
            r = $urandom_range(9);
            repeat (3)
                file_q.push_back((r == 0) ? 8'h00 : (r == 1) ? 8'hff : 8'($urandom));
        end

        if (fault == FAULT_CUT && file_q.size() > 1)
            repeat ($urandom_range(1, file_q.size() - 1))
                void'(file_q.pop_back());
    endtask

    task automatic send_byte(input logic [7:0] b, input logic first);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        data_byte  <= b;
        file_start <= first;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        phase_items++;
    endtask

    task automatic send_file();
        for (int i = 0; i < file_q.size(); i++)
            send_byte(file_q[i], i == 0);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (awaited != 0)
            @(posedge clk);
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        in_valid      <= 1'b0;
        data_byte     <= 8'h00;
        file_start    <= 1'b0;
        stall_pct     <= 0;
        hold_requests <= 0;
        idle_pct    = 0;
        phase_items = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // bad first byte, bad second byte, comment right after the magic, oversize width
        load_text("Q");
        send_file();
        load_text("P5");
        send_file();
        load_text("P6#\n2 1 9\n");
        repeat (3) file_q.push_back(8'h00);
        repeat (3) file_q.push_back(8'hff);
        send_file();
        load_text("P6\n4097");
        send_file();
        drain();

        for (int phase = 0; phase < 4; phase++)
        begin
            idle_pct = (phase == 1) ? 48 : (phase == 3) ? 37 : 0;
            stall_pct <= (phase == 2) ? 48 : (phase == 3) ? 37 : 0;
            // long receiver hold-off while requests keep coming
            if (phase == 0 || phase == 2)
                hold_requests <= hold_requests + 1;
            phase_items = 0;
            while (phase_items < RANDOM_ITEMS / 4)
            begin
                build_file();
                send_file();
            end
            drain();
        end

        repeat (8) @(posedge clk);
        if (fail_count == 0 && awaited == 0)
            $display("ppm_p6_gray_decoder: match");
        else
            $display("ppm_p6_gray_decoder: mismatch");
        $finish;
    end

endmodule
